FILE: rtl/isu_pkg.sv
package isu_pkg;

  localparam int PLAYERS       = 2;
  localparam int STRIPES       = 64;
  localparam int LIST_CAPACITY = 16;
  localparam int COORD_BITS    = 20;

  localparam int NLISTS   = PLAYERS * STRIPES;
  localparam int LIDX_W   = (NLISTS > 1) ? $clog2(NLISTS) : 1;
  localparam int ENT_W    = $clog2(LIST_CAPACITY);
  localparam int CNT_W    = $clog2(LIST_CAPACITY + 1);
  localparam int ADDR_W   = LIDX_W + ENT_W;
  localparam int ENT_BITS = 2 * COORD_BITS;
  localparam int REG_W    = 19;

  localparam logic [0:0] CFG_MIN_LENGTH = 1'b0;
  localparam logic [0:0] CFG_BOX_WIDTH  = 1'b1;

  localparam logic [REG_W-1:0] MIN_LENGTH_RST = REG_W'(26);
  localparam logic [REG_W-1:0] BOX_WIDTH_RST  = REG_W'(262144);

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_CLEAR  = 2'd1,
    FN_REVEAL = 2'd2,
    FN_READ   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    IX_INS = 2'd0,
    IX_REV = 2'd1,
    IX_RD  = 2'd2
  } idx_sel_t;

  typedef enum logic [1:0] {
    OK_ENTRY  = 2'd0,
    OK_EMPTY  = 2'd1,
    OK_STATUS = 2'd2
  } out_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CNT,
    S_CAP,
    S_DISPATCH,
    S_INS_CHK,
    S_INS_RD,
    S_INS_EV,
    S_INS_END,
    S_CP,
    S_INS_DONE,
    S_RV_RD,
    S_RV_WT,
    S_RD_RD,
    S_RD_OUT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic      latch;
    logic      cnt_rd;
    logic      cnt_cap;
    logic      ins_init;
    logic      ins_clamp;
    logic      k_clr;
    logic      k_inc;
    logic      mem_rd;
    idx_sel_t  rd_sel;
    logic      ev_step;
    logic      ins_end;
    logic      cp_step;
    logic      commit;
    logic      j_clr;
    logic      j_inc;
    logic      out_load;
    out_kind_t out_kind;
    logic      cnt_wr;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  addr_ok;
    logic  is_short;
    logic  nread_zero;
    logic  k_more;
    logic  i_more;
    logic  ev_stay;
    logic  cp_more;
    logic  rd_last;
    logic  out_busy;
  } stat_t;

endpackage

FILE: rtl/isu_ctrl.sv
module isu_ctrl import isu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_accept,
  input  stat_t stat,
  output logic  in_ready,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_CNT;
        end
      end
      S_CNT:      state_nxt = S_CAP;
      S_CAP:      state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        if (stat.func == FN_READ) begin
          state_nxt = stat.nread_zero ? S_FIN : S_RD_RD;
        end else if (!stat.addr_ok) begin
          state_nxt = S_FIN;
        end else begin
          case (stat.func)
            FN_INSERT: state_nxt = S_INS_CHK;
            FN_REVEAL: state_nxt = S_RV_RD;
            default:   state_nxt = S_FIN;
          endcase
        end
      end
      S_INS_CHK: state_nxt = stat.is_short ? S_INS_DONE : S_INS_RD;
      S_INS_RD:  state_nxt = stat.i_more ? S_INS_EV : S_INS_END;
      S_INS_EV:  state_nxt = stat.ev_stay ? S_INS_EV : S_INS_RD;
      S_INS_END: state_nxt = S_CP;
      S_CP: begin
        if (!stat.cp_more) begin
          state_nxt = S_INS_DONE;
        end
      end
      S_INS_DONE: state_nxt = (stat.func == FN_REVEAL) ? S_RV_RD : S_FIN;
      S_RV_RD:    state_nxt = stat.k_more ? S_RV_WT : S_FIN;
      S_RV_WT:    state_nxt = S_INS_CHK;
      S_RD_RD:    state_nxt = S_RD_OUT;
      S_RD_OUT: begin
        if (!stat.out_busy) begin
          state_nxt = stat.rd_last ? S_IDLE : S_RD_RD;
        end
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_accept;
      end
      S_CNT: cmd.cnt_rd = 1'b1;
      S_CAP: cmd.cnt_cap = 1'b1;
      S_DISPATCH: begin
        cmd.j_clr    = 1'b1;
        cmd.k_clr    = 1'b1;
        cmd.ins_init = (stat.func == FN_INSERT);
      end
      S_INS_RD: begin
        cmd.mem_rd = stat.i_more;
        cmd.rd_sel = IX_INS;
      end
      S_INS_EV:  cmd.ev_step = 1'b1;
      S_INS_END: begin
        cmd.ins_end = 1'b1;
        cmd.j_clr   = 1'b1;
      end
      S_CP: begin
        cmd.cp_step = stat.cp_more;
        cmd.commit  = !stat.cp_more;
      end
      S_INS_DONE: cmd.k_inc = (stat.func == FN_REVEAL);
      S_RV_RD: begin
        cmd.mem_rd = stat.k_more;
        cmd.rd_sel = IX_REV;
      end
      S_RV_WT: begin
        cmd.ins_init  = 1'b1;
        cmd.ins_clamp = 1'b1;
      end
      S_RD_RD: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_sel = IX_RD;
      end
      S_RD_OUT: begin
        cmd.out_load = !stat.out_busy;
        cmd.out_kind = OK_ENTRY;
        cmd.j_inc    = !stat.out_busy;
      end
      S_FIN: begin
        cmd.out_load = !stat.out_busy;
        cmd.out_kind = (stat.func == FN_READ) ? OK_EMPTY : OK_STATUS;
        cmd.cnt_wr   = !stat.out_busy && (stat.func != FN_READ) && stat.addr_ok;
      end
      default: cmd = '0;
    endcase
  end

endmodule

FILE: rtl/isu_dp.sv
module isu_dp import isu_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_idx,
  input  logic [REG_W-1:0]             cfg_wdata,
  input  func_t                        in_func,
  input  logic                         in_player,
  input  logic [5:0]                   in_stripe,
  input  logic                         in_bank,
  input  logic signed [COORD_BITS-1:0] in_left,
  input  logic signed [COORD_BITS-1:0] in_right,
  input  cmd_t                         cmd,
  output stat_t                        stat,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [COORD_BITS-1:0]        out_left,
  output logic [COORD_BITS-1:0]        out_right,
  output logic [CNT_W-1:0]             out_count,
  output logic                         out_ovf,
  output logic                         out_empty,
  output logic                         out_last
);

  localparam int CW = COORD_BITS;

  logic [REG_W-1:0] minl_r, box_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minl_r <= MIN_LENGTH_RST;
      box_r  <= BOX_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MIN_LENGTH: minl_r <= cfg_wdata;
        CFG_BOX_WIDTH:  box_r  <= cfg_wdata;
        default:        minl_r <= minl_r;
      endcase
    end
  end

  func_t              func_r;
  logic               addr_ok_r;
  logic [LIDX_W-1:0]  lidx_r;
  logic               bank_r;
  logic signed [CW-1:0] inl_r, inr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      func_r    <= FN_INSERT;
      addr_ok_r <= 1'b0;
    end else if (cmd.latch) begin
      func_r    <= in_func;
      addr_ok_r <= (int'(in_player) < PLAYERS) && (int'(in_stripe) < STRIPES);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lidx_r <= LIDX_W'(in_player) * LIDX_W'(STRIPES) + LIDX_W'(in_stripe);
      bank_r <= in_bank;
      inl_r  <= in_left;
      inr_r  <= in_right;
    end
  end

  logic [CNT_W-1:0] cnt_cur_mem [NLISTS];
  logic [CNT_W-1:0] cnt_rev_mem [NLISTS];
  logic [NLISTS-1:0] cur_v_r, rev_v_r;
  logic [CNT_W-1:0] cnt_cur_q, cnt_rev_q;
  logic [CNT_W-1:0] ncur_r, nrev_r;

  always_ff @(posedge clk) begin
    if (cmd.cnt_rd) begin
      cnt_cur_q <= cnt_cur_mem[lidx_r];
      cnt_rev_q <= cnt_rev_mem[lidx_r];
    end
    if (cmd.cnt_wr) begin
      case (func_r)
        FN_INSERT: cnt_cur_mem[lidx_r] <= ncur_r;
        FN_CLEAR:  cnt_cur_mem[lidx_r] <= '0;
        FN_REVEAL: cnt_rev_mem[lidx_r] <= nrev_r;
        default:   cnt_rev_mem[lidx_r] <= cnt_rev_mem[lidx_r];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= '0;
      rev_v_r <= '0;
    end else if (cmd.cnt_wr) begin
      if (func_r == FN_REVEAL) begin
        rev_v_r[lidx_r] <= 1'b1;
      end else begin
        cur_v_r[lidx_r] <= 1'b1;
      end
    end
  end

  logic               tgt_rev_r;
  logic signed [CW-1:0] pa_r, pb_r, mlo_r, mhi_r;
  logic               hit_r, emitted_r, skip_r, ovf_r;
  logic [CNT_W-1:0]   i_r, o_r, j_r, k_r;
  logic [ENT_BITS-1:0] scr [LIST_CAPACITY];
  logic [ENT_BITS-1:0] cur_q, rev_q;
  logic [ENT_BITS-1:0] cur_mem [NLISTS*LIST_CAPACITY];
  logic [ENT_BITS-1:0] rev_mem [NLISTS*LIST_CAPACITY];

  logic [CNT_W-1:0]   ntgt, nread;
  logic [ENT_BITS-1:0] held;
  logic signed [CW-1:0] elo, ehi, cqlo, cqhi, clo, chi;
  logic               ov, lies_left, full_drop;
  logic signed [CW+1:0] diff;
  logic [ENT_W-1:0]   ridx;
  logic               rrev;

  assign ntgt  = tgt_rev_r ? nrev_r : ncur_r;
  assign nread = !addr_ok_r ? '0 : (bank_r ? nrev_r : ncur_r);
  assign held  = tgt_rev_r ? rev_q : cur_q;
  assign elo   = held[CW-1:0];
  assign ehi   = held[ENT_BITS-1:CW];
  assign ov    = (elo < pb_r) && (pa_r < ehi);
  assign lies_left = (ehi <= pa_r);
  assign full_drop = !hit_r && (ntgt == CNT_W'(LIST_CAPACITY));
  assign cqlo  = cur_q[CW-1:0];
  assign cqhi  = cur_q[ENT_BITS-1:CW];
  assign clo   = (cqlo < 0) ? '0 : cqlo;
  assign chi   = ($signed({cqhi[CW-1], cqhi}) > $signed((CW+1)'(box_r))) ?
                 CW'(box_r) : cqhi;
  assign diff  = $signed({{2{pb_r[CW-1]}}, pb_r}) - $signed({{2{pa_r[CW-1]}}, pa_r});

  always_comb begin
    case (cmd.rd_sel)
      IX_INS: begin
        ridx = i_r[ENT_W-1:0];
        rrev = tgt_rev_r;
      end
      IX_REV: begin
        ridx = k_r[ENT_W-1:0];
        rrev = 1'b0;
      end
      IX_RD: begin
        ridx = j_r[ENT_W-1:0];
        rrev = bank_r;
      end
      default: begin
        ridx = '0;
        rrev = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd && !rrev) begin
      cur_q <= cur_mem[{lidx_r, ridx}];
    end
    if (cmd.cp_step && !tgt_rev_r) begin
      cur_mem[{lidx_r, j_r[ENT_W-1:0]}] <= scr[j_r[ENT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd && rrev) begin
      rev_q <= rev_mem[{lidx_r, ridx}];
    end
    if (cmd.cp_step && tgt_rev_r) begin
      rev_mem[{lidx_r, j_r[ENT_W-1:0]}] <= scr[j_r[ENT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ev_step && o_r < CNT_W'(LIST_CAPACITY) && !ov) begin
      if (lies_left || emitted_r) begin
        scr[o_r[ENT_W-1:0]] <= held;
      end else begin
        scr[o_r[ENT_W-1:0]] <= {mhi_r, mlo_r};
      end
    end else if (cmd.ins_end && !emitted_r && !(!hit_r && ntgt == CNT_W'(LIST_CAPACITY))
                 && o_r < CNT_W'(LIST_CAPACITY)) begin
      scr[o_r[ENT_W-1:0]] <= {mhi_r, mlo_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_cap) begin
      ncur_r <= cur_v_r[lidx_r] ? cnt_cur_q : '0;
      nrev_r <= rev_v_r[lidx_r] ? cnt_rev_q : '0;
    end else if (cmd.commit && !skip_r) begin
      if (tgt_rev_r) begin
        nrev_r <= o_r;
      end else begin
        ncur_r <= o_r;
      end
    end
    if (cmd.ins_init) begin
      tgt_rev_r <= cmd.ins_clamp;
      pa_r      <= cmd.ins_clamp ? clo : inl_r;
      pb_r      <= cmd.ins_clamp ? chi : inr_r;
      mlo_r     <= cmd.ins_clamp ? clo : inl_r;
      mhi_r     <= cmd.ins_clamp ? chi : inr_r;
      hit_r     <= 1'b0;
      emitted_r <= 1'b0;
      skip_r    <= 1'b0;
      i_r       <= '0;
      o_r       <= '0;
    end else if (cmd.ev_step) begin
      if (ov) begin
        mlo_r <= (elo < mlo_r) ? elo : mlo_r;
        mhi_r <= (ehi > mhi_r) ? ehi : mhi_r;
        hit_r <= 1'b1;
        i_r   <= i_r + 1'b1;
      end else if (lies_left || emitted_r) begin
        o_r <= o_r + 1'b1;
        i_r <= i_r + 1'b1;
      end else begin
        o_r       <= o_r + 1'b1;
        emitted_r <= 1'b1;
        skip_r    <= full_drop;
      end
    end else if (cmd.ins_end && !emitted_r) begin
      if (!hit_r && ntgt == CNT_W'(LIST_CAPACITY)) begin
        skip_r <= 1'b1;
      end else begin
        o_r <= o_r + 1'b1;
      end
    end
    if (cmd.k_clr) begin
      k_r <= '0;
    end else if (cmd.k_inc) begin
      k_r <= k_r + 1'b1;
    end
    if (cmd.j_clr) begin
      j_r <= '0;
    end else if (cmd.j_inc || cmd.cp_step) begin
      j_r <= j_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r <= 1'b0;
    end else if (cmd.latch) begin
      ovf_r <= 1'b0;
    end else if (((cmd.ev_step && !ov && !lies_left) || cmd.ins_end) && !emitted_r &&
                 full_drop) begin
      ovf_r <= 1'b1;
    end
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_kind)
        OK_ENTRY: begin
          out_left  <= bank_r ? rev_q[CW-1:0] : cur_q[CW-1:0];
          out_right <= bank_r ? rev_q[ENT_BITS-1:CW] : cur_q[ENT_BITS-1:CW];
          out_count <= nread;
          out_ovf   <= 1'b0;
          out_empty <= 1'b0;
          out_last  <= stat.rd_last;
        end
        OK_EMPTY: begin
          out_left  <= '0;
          out_right <= '0;
          out_count <= '0;
          out_ovf   <= 1'b0;
          out_empty <= 1'b1;
          out_last  <= 1'b1;
        end
        default: begin
          out_left  <= '0;
          out_right <= '0;
          out_ovf   <= addr_ok_r && ovf_r;
          out_empty <= 1'b0;
          out_last  <= 1'b1;
          if (!addr_ok_r) begin
            out_count <= '0;
          end else begin
            case (func_r)
              FN_INSERT: out_count <= ncur_r;
              FN_REVEAL: out_count <= nrev_r;
              default:   out_count <= '0;
            endcase
          end
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    stat            = '0;
    stat.func       = func_r;
    stat.addr_ok    = addr_ok_r;
    stat.is_short   = diff < $signed((CW+2)'(minl_r));
    stat.nread_zero = (nread == '0);
    stat.k_more     = (k_r < ncur_r);
    stat.i_more     = (i_r < ntgt);
    stat.ev_stay    = !ov && !lies_left && !emitted_r;
    stat.cp_more    = !skip_r && (j_r < o_r);
    stat.rd_last    = (CNT_W'(j_r + 1'b1) == nread);
    stat.out_busy   = out_valid_r;
  end

endmodule

FILE: rtl/interval_set_union_store.sv
// Stores, for each player and stripe, a current and a revealed sorted list of disjoint
// intervals, up to LIST_CAPACITY each, in two single-port RAMs walked one entry at a time.
// A request is taken only while the block is idle. Insert reads and merges each stored
// entry of a list of n intervals, then copies the merged list back one entry at a time.
// Reveal runs one such insert per current interval. Read returns n results. Interval
// storage needs no clearing after reset; list counts read as zero until first written.
module interval_set_union_store import isu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_idx,
  input  logic [REG_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [47:0]      in_tdata,  // player, stripe, bank, left_edge, right_edge
  input  logic [1:0]       in_tuser,  // func
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [47:0]      out_tdata, // out_left, out_right, list_count, overflow, empty_res
  output logic             out_tlast
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_accept;
  logic [COORD_BITS-1:0] o_left, o_right;
  logic [CNT_W-1:0] o_count;
  logic o_ovf, o_empty;

  assign in_accept = in_tvalid && in_tready;

  isu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_accept(in_accept),
    .stat     (stat),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  isu_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_func  (func_t'(in_tuser)),
    .in_player(in_tdata[0]),
    .in_stripe(in_tdata[6:1]),
    .in_bank  (in_tdata[7]),
    .in_left  (in_tdata[27:8]),
    .in_right (in_tdata[47:28]),
    .cmd      (cmd),
    .stat     (stat),
    .out_ready(out_tready),
    .out_valid(out_tvalid),
    .out_left (o_left),
    .out_right(o_right),
    .out_count(o_count),
    .out_ovf  (o_ovf),
    .out_empty(o_empty),
    .out_last (out_tlast)
  );

  assign out_tdata = {1'b0, o_empty, o_ovf, o_count, o_right, o_left};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[44:40] <= 5'(LIST_CAPACITY)))
    else $error("list count above capacity");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[46]) |-> (out_tlast && out_tdata[44:40] == '0 && !out_tdata[45]))
    else $error("empty read result malformed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("request taken while busy");

endmodule

FILE: dv/interval_set_union_store_tb.sv
`timescale 1ns / 100ps

module interval_set_union_store_tb;
  import isu_pkg::*;

  typedef struct {
    logic [19:0] left_end;
    logic [19:0] right_end;
    logic [4:0]  count;
    logic        ovf;
    logic        empty;
    logic        last;
  } list_answer_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [0:0]       cfg_idx;
  logic [REG_W-1:0] cfg_wdata;
  logic             in_tvalid;
  logic             in_tready;
  logic [47:0]      in_tdata;
  logic [1:0]       in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [47:0]      out_tdata;
  logic             out_tlast;

  list_answer_t answer_mem[4096];
  int ans_wr;
  int ans_rd;
  int lo_end[2][NLISTS][LIST_CAPACITY];
  int hi_end[2][NLISTS][LIST_CAPACITY];
  int list_len[2][NLISTS];
  int min_len;
  int box_w;
  int burst_left;
  int mismatches;
  int results_seen;
  int overflows_seen;
  int merges_seen;
  int requests_sent;

  interval_set_union_store u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results still outstanding.", ans_wr - ans_rd);
    $display("status: fail");
    $finish;
  end

  function automatic bit union_add(int bk, int id, int a, int b);
    int f, g, pos, n, gone, i;
    bit hit;
    f = 0; g = 0; pos = 0; hit = 0;
    if (b - a < min_len) return 0;
    n = list_len[bk][id];
    for (i = 0; i < n; i++) begin
      if (lo_end[bk][id][i] < b && a < hi_end[bk][id][i]) begin
        if (!hit) f = i;
        g = i;
        hit = 1;
      end
      if (hi_end[bk][id][i] <= a) pos = i + 1;
    end
    if (hit) begin
      merges_seen++;
      gone = g - f;
      if (a < lo_end[bk][id][f]) lo_end[bk][id][f] = a;
      hi_end[bk][id][f] = (b > hi_end[bk][id][g]) ? b : hi_end[bk][id][g];
      for (i = g + 1; i < n; i++) begin
        lo_end[bk][id][i - gone] = lo_end[bk][id][i];
        hi_end[bk][id][i - gone] = hi_end[bk][id][i];
      end
      list_len[bk][id] = n - gone;
      return 0;
    end
    if (n >= LIST_CAPACITY) return 1;
    for (i = n; i > pos; i--) begin
      lo_end[bk][id][i] = lo_end[bk][id][i - 1];
      hi_end[bk][id][i] = hi_end[bk][id][i - 1];
    end
    lo_end[bk][id][pos] = a;
    hi_end[bk][id][pos] = b;
    list_len[bk][id] = n + 1;
    return 0;
  endfunction

  function automatic void push_answer(int l, int r, int c, bit o, bit e, bit t);
    list_answer_t ans;
    ans.left_end  = l[19:0];
    ans.right_end = r[19:0];
    ans.count     = c[4:0];
    ans.ovf       = o;
    ans.empty     = e;
    ans.last      = t;
    answer_mem[ans_wr[11:0]] = ans;
    ans_wr++;
  endfunction

  function automatic void predict_request(func_t fn, logic [47:0] d);
    int id, a, b, n, i, l, r;
    bit bk, ovf;
    id = d[0] * STRIPES + d[6:1];
    bk = d[7];
    a = int'($signed(d[27:8]));
    b = int'($signed(d[47:28]));
    ovf = 0;
    case (fn)
      FN_INSERT: begin
        ovf = union_add(0, id, a, b);
        push_answer(0, 0, list_len[0][id], ovf, 0, 1);
      end
      FN_CLEAR: begin
        list_len[0][id] = 0;
        push_answer(0, 0, 0, 0, 0, 1);
      end
      FN_REVEAL: begin
        n = list_len[0][id];
        for (i = 0; i < n; i++) begin
          l = lo_end[0][id][i] < 0 ? 0 : lo_end[0][id][i];
          r = hi_end[0][id][i] > box_w ? box_w : hi_end[0][id][i];
          ovf |= union_add(1, id, l, r);
        end
        push_answer(0, 0, list_len[1][id], ovf, 0, 1);
      end
      default: begin
        n = list_len[bk][id];
        if (n == 0) push_answer(0, 0, 0, 0, 1, 1);
        for (i = 0; i < n; i++)
          push_answer(lo_end[bk][id][i], hi_end[bk][id][i], n, 0, 0, i + 1 == n);
      end
    endcase
    if (ovf) overflows_seen++;
  endfunction

  task automatic send_request(func_t fn, bit p, int s, bit bk, int a, int b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {b[19:0], a[19:0], bk, s[5:0], p};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_request(fn, {b[19:0], a[19:0], bk, s[5:0], p});
    requests_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (ans_wr != ans_rd) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, int value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value[REG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_MIN_LENGTH) min_len = value;
    else box_w = value;
  endtask

  task automatic test_directed();
    send_request(FN_READ, 0, 5, 0, 0, 0);
    send_request(FN_READ, 1, 63, 1, 0, 0);
    send_request(FN_INSERT, 0, 5, 0, 100, 300);
    send_request(FN_INSERT, 0, 5, 0, 300, 500);
    send_request(FN_INSERT, 0, 5, 0, 600, 610);
    send_request(FN_INSERT, 0, 5, 1, 900, 700);
    send_request(FN_INSERT, 0, 5, 0, 250, 350);
    send_request(FN_INSERT, 0, 5, 0, -524288, 524287);
    send_request(FN_INSERT, 1, 63, 0, -3000, -1000);
    send_request(FN_INSERT, 1, 63, 0, 262000, 270000);
    send_request(FN_INSERT, 1, 63, 0, -50, 40);
    send_request(FN_REVEAL, 1, 63, 0, 0, 0);
    send_request(FN_READ, 1, 63, 1, 0, 0);
    send_request(FN_READ, 0, 5, 0, 0, 0);
    send_request(FN_CLEAR, 0, 5, 0, 0, 0);
    send_request(FN_READ, 0, 5, 0, 0, 0);
    drain_results();
  endtask

  task automatic test_full_list();
    int i;
    write_reg(CFG_MIN_LENGTH, 0);
    for (i = 0; i < 17; i++)
      send_request(FN_INSERT, 1, 0, 0, i * 10, i * 10);
    send_request(FN_INSERT, 1, 0, 0, 5, 5);
    send_request(FN_READ, 1, 0, 0, 0, 0);
    send_request(FN_REVEAL, 1, 0, 0, 0, 0);
    send_request(FN_READ, 1, 0, 1, 0, 0);
    send_request(FN_INSERT, 1, 0, 0, -1, 171);
    send_request(FN_READ, 1, 0, 0, 0, 0);
  endtask

  task automatic test_random(int items, int span);
    int k, a, len, s;
    func_t fn;
    bit p;
    for (k = 0; k < items; k++) begin
      p = $urandom_range(0, 1);
      s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(8, 10);
      case ($urandom_range(0, 19))
        0, 1:          fn = FN_CLEAR;
        2, 3, 4:       fn = FN_REVEAL;
        5, 6, 7, 8, 9: fn = FN_READ;
        default:       fn = FN_INSERT;
      endcase
      if ($urandom_range(0, 9) == 0) begin
        a = $urandom_range(0, 1048575) - 524288;
        len = $urandom_range(0, 1048575) - 524288;
        send_request(fn, p, s, $urandom_range(0, 1), a, len);
      end else begin
        a = $urandom_range(0, span) - span / 8;
        len = $urandom_range(0, span / 10) - 30;
        send_request(fn, p, s, $urandom_range(0, 1), a, a + len);
      end
      if (k == items / 2) drain_results();
    end
    drain_results();
  endtask

  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      case ($urandom_range(0, 3))
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        2: out_tready <= ($urandom_range(0, 4) == 0);
        default: out_tready <= ($urandom_range(0, 4) != 0);
      endcase
      repeat ($urandom_range(0, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    list_answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (ans_wr == ans_rd) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h last %b", out_tdata, out_tlast);
      end else begin
        want = answer_mem[ans_rd[11:0]];
        ans_rd++;
        if (out_tdata[19:0] !== want.left_end || out_tdata[39:20] !== want.right_end ||
            out_tdata[44:40] !== want.count || out_tdata[45] !== want.ovf ||
            out_tdata[46] !== want.empty || out_tdata[47] !== 1'b0 ||
            out_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected l=%h r=%h n=%0d ovf=%b emp=%b last=%b, got %h last %b",
                     want.left_end, want.right_end, want.count, want.ovf, want.empty,
                     want.last, out_tdata, out_tlast);
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_MIN_LENGTH;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = FN_INSERT;
    ans_wr = 0;
    ans_rd = 0;
    min_len = 26;
    box_w = 262144;
    burst_left = 0;
    mismatches = 0;
    results_seen = 0;
    overflows_seen = 0;
    merges_seen = 0;
    requests_sent = 0;
    for (int b = 0; b < 2; b++)
      for (int i = 0; i < NLISTS; i++) list_len[b][i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_list();
    write_reg(CFG_MIN_LENGTH, 26);
    write_reg(CFG_BOX_WIDTH, 262144);
    test_random(30, 40000);
    write_reg(CFG_MIN_LENGTH, 0);
    write_reg(CFG_BOX_WIDTH, 1500);
    test_random(25, 4000);
    write_reg(CFG_BOX_WIDTH, 0);
    test_random(8, 4000);
    write_reg(CFG_MIN_LENGTH, 524287);
    write_reg(CFG_BOX_WIDTH, 524287);
    test_random(8, 4000);
    drain_results();
    $display("Sent %0d requests and checked %0d results over four register settings.",
             requests_sent, results_seen);
    $display("Saw %0d merges and %0d list overflows; %0d mismatches.",
             merges_seen, overflows_seen, mismatches);
    if (mismatches == 0 && ans_wr == ans_rd) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
